### rtl/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, cell codes, beat types and controller/datapath links.
// ----------------------------------------------------------------------------
package tmcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int CELL_W  = 16;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 8;

   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
   localparam logic [CELL_W-1:0]  BLANK_CELL   = 16'h0220;
   localparam logic [CELL_W-1:0]  ZERO_CELL    = 16'h0000;
   localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h02;

   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic              command;
      logic [CHAR_W-1:0] char_byte;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_column;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_value;
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_column;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic clr_cnt;
      logic inc_cnt;
      logic wr_blank;
      logic wr_zero;
      logic wr_copy;
      logic wr_char;
      logic rd_cell;
      logic rd_copy;
      logic adv_cursor;
      logic newline;
      logic respond;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_read;
      logic is_newline;
      logic on_bottom;
      logic cnt_last;
      logic copy_last;
   } ctrl_status_type;

   function automatic logic [ADDR_W-1:0] cell_address(input logic [ROW_W-1:0] row,
                                                      input logic [COL_W-1:0] col);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(row) * ADDR_W'(COLUMNS);
      return base + ADDR_W'(col);
   endfunction

endpackage

### rtl/tmcw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences the clearing pass, put/read handling and the scroll copy.
// ----------------------------------------------------------------------------
module tmcw_ctrl import tmcw_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_DISPATCH = 3'd2;
   localparam logic [2:0] S_COPY_RD  = 3'd3;
   localparam logic [2:0] S_COPY_WR  = 3'd4;
   localparam logic [2:0] S_ZERO     = 3'd5;
   localparam logic [2:0] S_RESPOND  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.wr_blank = 1'b1;
            if (status.cnt_last) begin
               cmd.clr_cnt = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.inc_cnt = 1'b1;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.is_read) begin
               cmd.rd_cell = 1'b1;
               state_in    = S_RESPOND;
            end else if (status.is_newline && status.on_bottom) begin
               cmd.clr_cnt = 1'b1;
               state_in    = S_COPY_RD;
            end else if (status.is_newline) begin
               cmd.newline = 1'b1;
               state_in    = S_RESPOND;
            end else begin
               cmd.wr_char    = 1'b1;
               cmd.adv_cursor = 1'b1;
               state_in       = S_RESPOND;
            end
         end
         // move each cell up one row: fetch from the row below, then store
         S_COPY_RD: begin
            cmd.rd_copy = 1'b1;
            state_in    = S_COPY_WR;
         end
         S_COPY_WR: begin
            cmd.wr_copy = 1'b1;
            cmd.inc_cnt = 1'b1;
            state_in    = status.copy_last ? S_ZERO : S_COPY_RD;
         end
         S_ZERO: begin
            cmd.wr_zero = 1'b1;
            if (status.cnt_last) begin
               cmd.clr_cnt = 1'b1;
               cmd.newline = 1'b1;
               state_in    = S_RESPOND;
            end else begin
               cmd.inc_cnt = 1'b1;
            end
         end
         S_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### rtl/tmcw_datapath.sv
// ----------------------------------------------------------------------------
// Text console writer datapath
// Screen memory, cursor, text colour, sweep counter and result register.
// ----------------------------------------------------------------------------
module tmcw_datapath import tmcw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  req_type            req_item,
   input  logic               csr_write,
   input  logic [COLOR_W-1:0] csr_data,
   input  ctrl_cmd_type       cmd,
   output ctrl_status_type    status,
   output logic               rsp_strobe,
   output rsp_type            rsp_item
);

   logic [CELL_W-1:0] screen_mem [CELL_COUNT];

   req_type            req_ff;
   logic [ADDR_W-1:0]  cnt_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [COL_W-1:0]   col_ff;
   logic [COLOR_W-1:0] color_ff;
   logic [CELL_W-1:0]  rdata_ff;
   rsp_type            rsp_ff;
   logic               rsp_strobe_ff;

   logic               in_range;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [CELL_W-1:0]  wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ROW_W-1:0]   row_in;
   logic [COL_W-1:0]   col_in;
   logic [CELL_W-1:0]  cell_in;

   assign in_range = (req_ff.read_row < ROW_W'(ROWS)) &&
                     (req_ff.read_column < COL_W'(COLUMNS));

   assign status.is_read    = (req_ff.command == CMD_READ);
   assign status.is_newline = (req_ff.char_byte == NEWLINE_CODE);
   assign status.on_bottom  = (row_ff == ROW_W'(ROWS - 1));
   assign status.cnt_last   = (cnt_ff == ADDR_W'(CELL_COUNT - 1));
   assign status.copy_last  = (cnt_ff == ADDR_W'(CELL_COUNT - COLUMNS - 1));

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.clr_cnt) begin
         cnt_ff <= '0;
      end else if (cmd.inc_cnt) begin
         cnt_ff <= cnt_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= COLOR_RESET;
      end else if (csr_write) begin
         color_ff <= csr_data;
      end
   end

   // screen memory: one write and one read port, read data registered
   assign wr_en   = cmd.wr_blank | cmd.wr_zero | cmd.wr_copy | cmd.wr_char;
   assign wr_addr = cmd.wr_char ? cell_address(row_ff, col_ff) : cnt_ff;

   always_comb begin
      if (cmd.wr_char) begin
         wr_data = {color_ff, req_ff.char_byte};
      end else if (cmd.wr_copy) begin
         wr_data = rdata_ff;
      end else if (cmd.wr_blank) begin
         wr_data = BLANK_CELL;
      end else begin
         wr_data = ZERO_CELL;
      end
   end

   assign rd_en   = (cmd.rd_cell & in_range) | cmd.rd_copy;
   assign rd_addr = cmd.rd_cell ? cell_address(req_ff.read_row, req_ff.read_column)
                                : cnt_ff + ADDR_W'(COLUMNS);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= screen_mem[rd_addr];
      end
   end

   // cursor
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.newline) begin
         col_in = '0;
         if (!status.on_bottom) begin
            row_in = row_ff + ROW_W'(1);
         end
      end else if (cmd.adv_cursor) begin
         if (col_ff == COL_W'(COLUMNS - 1)) begin
            col_in = '0;
            row_in = status.on_bottom ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // result beat
   assign cell_in = (status.is_read && in_range) ? rdata_ff : ZERO_CELL;

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff.cell_value    <= cell_in;
         rsp_ff.cursor_row    <= row_ff;
         rsp_ff.cursor_column <= col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

### rtl/text_mode_console_writer_unit.sv
// ----------------------------------------------------------------------------
// Text mode console writer
// Character stream in, 80x25 screen of colour cells, one result per command.
//
//   channel  ports                               beat taken when
//   request  start, busy, req_item               start && !busy
//   result   rsp_strobe, rsp_item                rsp_strobe (one cycle)
//   csr      csr_valid, csr_ready, csr_data      csr_valid && csr_ready
//
// A put or read passes the dispatch and respond states before its strobe;
// the next command is taken in the strobe cycle. A newline on the bottom
// row scrolls: the 1920 moved cells are each read from the row below and
// written back one row up, then 80 zero writes clear the bottom row.
// After reset a clearing pass fills all 2000 cells with blanks; busy
// stays high meanwhile. The result side cannot stall.
// ----------------------------------------------------------------------------
module text_mode_console_writer_unit import tmcw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_item,
   output logic               rsp_strobe,
   output rsp_type            rsp_item,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COLOR_W-1:0] csr_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_ready = 1'b1;

   tmcw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   tmcw_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .csr_write  (csr_valid & csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // a result only appears once the controller is back to taking commands
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> !busy)
      else $error("result beat while busy");

   // an accepted command holds the block busy next cycle
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   // reported cursor stays on the screen
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.cursor_row < ROW_W'(ROWS)) &&
                     (rsp_item.cursor_column < COL_W'(COLUMNS)))
      else $error("cursor off screen");

   // strobe is a single-cycle pulse per command
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

endmodule
